// ----- rtl/core/stl_pkg.sv -----
// Shared constants, types and helpers for the staircase level core.
`default_nettype none

package stl_pkg;

  localparam int LEVELS         = 4;
  localparam int NUM_SEGS       = 4 * LEVELS + 1;
  localparam int NUM_EDGES      = 4 * LEVELS + 2;
  localparam int PHASE_BITS_DEF = 16;

  localparam int PHASE_W    = 16;
  localparam int ALPHA_W    = 15;
  localparam int LEAD_W     = 16;
  localparam int SEG_W      = 5;
  localparam int LEVEL_W    = 4;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [LEVELS-1:0][ALPHA_W-1:0] alpha_vec_t;

  localparam alpha_vec_t ALPHA_RST = {15'd12743, 15'd9102, 15'd5461, 15'd1820};
  localparam logic [LEAD_W-1:0] LEAD_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_1    = 3'd0,
    CFG_ALPHA_2    = 3'd1,
    CFG_ALPHA_3    = 3'd2,
    CFG_ALPHA_4    = 3'd3,
    CFG_PHASE_LEAD = 3'd4
  } cfg_reg_t;

  // Signed width that holds every mirrored edge and the led phase.
  function automatic int edge_w(input int pb);
    return ((pb > PHASE_W) ? pb : PHASE_W) + 2;
  endfunction

  // Level of a segment: 0 up to LEVELS, back to 0, down to -LEVELS, back to 0.
  function automatic logic signed [LEVEL_W-1:0] seg_level(input logic [SEG_W-1:0] s);
    logic signed [LEVEL_W-1:0] lv;
    int si;
    si = int'(s);
    if (si <= LEVELS) begin
      lv = LEVEL_W'(si);
    end else if (si <= 2 * LEVELS) begin
      lv = LEVEL_W'(2 * LEVELS - si);
    end else if (si <= 3 * LEVELS) begin
      lv = LEVEL_W'(2 * LEVELS - si);
    end else begin
      lv = LEVEL_W'(si - 4 * LEVELS);
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stl_edge_gen.sv -----
// Mirrors the quarter-wave switching angles into the full-turn edge table.
`default_nettype none

module stl_edge_gen #(
  parameter int PHASE_BITS = stl_pkg::PHASE_BITS_DEF
) (
  input  wire stl_pkg::alpha_vec_t alpha_i,
  output logic [stl_pkg::NUM_EDGES-1:0][stl_pkg::edge_w(PHASE_BITS)-1:0] edge_o
);

  localparam int EW = stl_pkg::edge_w(PHASE_BITS);
  localparam int L  = stl_pkg::LEVELS;
  localparam logic [EW-1:0] TURN = EW'(1) << PHASE_BITS;
  localparam logic [EW-1:0] HALF = EW'(1) << (PHASE_BITS - 1);

  assign edge_o[0]       = '0;
  assign edge_o[4*L + 1] = TURN;

  for (genvar k = 1; k <= L; k++) begin : g_edge
    assign edge_o[k]       = EW'(alpha_i[k-1]);
    assign edge_o[L + k]   = HALF - EW'(alpha_i[L-k]);
    assign edge_o[2*L + k] = HALF + EW'(alpha_i[k-1]);
    assign edge_o[3*L + k] = TURN - EW'(alpha_i[L-k]);
  end

endmodule

`default_nettype wire

// ----- rtl/core/stl_seg_find.sv -----
// Segment search over the edge table, level lookup and distance to next edge.
`default_nettype none

module stl_seg_find #(
  parameter int PHASE_BITS = stl_pkg::PHASE_BITS_DEF
) (
  input  wire [stl_pkg::NUM_EDGES-1:0][stl_pkg::edge_w(PHASE_BITS)-1:0] edge_i,
  input  wire [stl_pkg::edge_w(PHASE_BITS)-1:0]                         phase_i,
  output logic [stl_pkg::SEG_W-1:0]                                     seg_o,
  output logic signed [stl_pkg::LEVEL_W-1:0]                            level_o,
  output logic [stl_pkg::DIST_W-1:0]                                    dist_o
);

  localparam int EW = stl_pkg::edge_w(PHASE_BITS);
  localparam logic signed [EW-1:0] DIST_MAX = EW'((64'd1 << stl_pkg::DIST_W) - 64'd1);

  logic [EW-1:0]        next_edge;
  logic signed [EW-1:0] diff;

  // Last match wins: coinciding edges select the later segment.
  always_comb begin
    seg_o     = '0;
    next_edge = edge_i[1];
    for (int s = 0; s < stl_pkg::NUM_SEGS; s++) begin
      if ($signed(edge_i[s]) <= $signed(phase_i)) begin
        seg_o     = stl_pkg::SEG_W'(s);
        next_edge = edge_i[s+1];
      end
    end
  end

  assign diff    = $signed(next_edge) - $signed(phase_i);
  assign level_o = stl_pkg::seg_level(seg_o);

  always_comb begin
    if (diff < 0) begin
      dist_o = '0;
    end else if (diff > DIST_MAX) begin
      dist_o = '1;
    end else begin
      dist_o = diff[stl_pkg::DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/staircase_level_from_phase_core.sv -----
// Top level of the nine-level staircase modulator core.
// A phase beat is led by phase_lead (mod one turn of 2^PHASE_BITS), registered, then
// compared in parallel against the 18 mirrored switching edges; the segment, its level
// (-4..4) and the distance to the next edge are registered in the output register.
// One beat is taken every cycle while the output is not stalled; while a result waits,
// stage 1 still takes a new beat if it is empty. Configuration writes are registered
// and cfg_ready is always high; write only while no beat is in flight.
`default_nettype none

module staircase_level_from_phase_core #(
  parameter int PHASE_BITS = stl_pkg::PHASE_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire [stl_pkg::PHASE_W-1:0]             in_phase,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic [stl_pkg::SEG_W-1:0]              out_segment,
  output logic signed [stl_pkg::LEVEL_W-1:0]     out_level,
  output logic [stl_pkg::DIST_W-1:0]             out_phase_to_next,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [stl_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [stl_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int EW = stl_pkg::edge_w(PHASE_BITS);
  localparam logic [EW-1:0] PHASE_MASK = (EW'(1) << PHASE_BITS) - EW'(1);

  stl_pkg::alpha_vec_t              alpha_r;
  logic [stl_pkg::LEAD_W-1:0]       lead_r;

  logic                             s1_v_r, s1_v_nxt;
  logic [EW-1:0]                    s1_phase_r;
  logic                             out_v_r, out_v_nxt;
  logic [stl_pkg::SEG_W-1:0]        seg_r;
  logic signed [stl_pkg::LEVEL_W-1:0] level_r;
  logic [stl_pkg::DIST_W-1:0]       dist_r;

  logic                             out_adv;
  logic                             s1_ready;
  logic [stl_pkg::PHASE_W:0]        led_sum;
  logic [EW-1:0]                    led_phase;

  logic [stl_pkg::NUM_EDGES-1:0][EW-1:0] edges;
  logic [stl_pkg::SEG_W-1:0]        seg_c;
  logic signed [stl_pkg::LEVEL_W-1:0] level_c;
  logic [stl_pkg::DIST_W-1:0]       dist_c;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= stl_pkg::ALPHA_RST;
      lead_r  <= stl_pkg::LEAD_RST;
    end else if (cfg_valid) begin
      unique case (stl_pkg::cfg_reg_t'(cfg_index))
        stl_pkg::CFG_ALPHA_1:    alpha_r[0] <= cfg_data[stl_pkg::ALPHA_W-1:0];
        stl_pkg::CFG_ALPHA_2:    alpha_r[1] <= cfg_data[stl_pkg::ALPHA_W-1:0];
        stl_pkg::CFG_ALPHA_3:    alpha_r[2] <= cfg_data[stl_pkg::ALPHA_W-1:0];
        stl_pkg::CFG_ALPHA_4:    alpha_r[3] <= cfg_data[stl_pkg::ALPHA_W-1:0];
        stl_pkg::CFG_PHASE_LEAD: lead_r     <= cfg_data[stl_pkg::LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_adv  = !out_v_r || out_ready;
  assign s1_ready = !s1_v_r || out_adv;
  assign in_ready = s1_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_valid;
    end
    out_v_nxt = out_v_r;
    if (out_adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Stage 1: led phase, wrapped to one turn
  assign led_sum   = {1'b0, in_phase} + {1'b0, lead_r};
  assign led_phase = EW'(led_sum) & PHASE_MASK;

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_phase_r <= led_phase;
    end
  end

  // Stage 2: edge compare and result
  stl_edge_gen #(
    .PHASE_BITS (PHASE_BITS)
  ) u_edge_gen (
    .alpha_i (alpha_r),
    .edge_o  (edges)
  );

  stl_seg_find #(
    .PHASE_BITS (PHASE_BITS)
  ) u_seg_find (
    .edge_i  (edges),
    .phase_i (s1_phase_r),
    .seg_o   (seg_c),
    .level_o (level_c),
    .dist_o  (dist_c)
  );

  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      seg_r   <= seg_c;
      level_r <= level_c;
      dist_r  <= dist_c;
    end
  end

  assign out_valid         = out_v_r;
  assign out_segment       = seg_r;
  assign out_level         = level_r;
  assign out_phase_to_next = dist_r;

  // Checks
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (int'(seg_r) < stl_pkg::NUM_SEGS))
    else $error("segment out of range");

  a_level_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (level_r == stl_pkg::seg_level(seg_r)))
    else $error("level does not match segment");

  a_dist_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (dist_r != '0))
    else $error("zero distance to next edge");

  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted beat lost in stage 1");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_adv) |=> out_v_r)
    else $error("stage 1 beat not moved to output");

endmodule

`default_nettype wire
